// File: rtl/assert_macros.svh
// Assertion macros included by the Savitzky-Golay core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SGSD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sgsd assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SGSD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sgsd assertion failed");

`endif

// File: rtl/sgsd_pkg.sv
package sgsd_pkg;

    localparam int HALF_WINDOW = 5;
    localparam int TAPS        = 2 * HALF_WINDOW + 1;
    localparam int SAMPLE_W    = 16;
    localparam int COEF_W      = 16;
    localparam int ACC_W       = 36;
    localparam int OUT_W       = 32;
    localparam int OUT_SHIFT   = 8;
    localparam int FILL_W      = $clog2(TAPS + 1);

    typedef logic        [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEF_W-1:0]   t_coef;
    typedef logic signed [ACC_W-1:0]    t_acc;
    typedef logic signed [OUT_W-1:0]    t_out;
    typedef logic        [FILL_W-1:0]   t_fill;

    typedef struct packed {
        t_coef smooth;
        t_coef first;
        t_coef second;
    } t_coef_set;

    typedef struct packed {
        t_acc smooth;
        t_acc first;
        t_acc second;
    } t_sums;

    typedef struct packed {
        t_out smoothed;
        t_out first_derivative;
        t_out second_derivative;
    } t_result;

    localparam t_fill FILL_FULL = t_fill'(TAPS);
    localparam t_fill FILL_LAST = t_fill'(TAPS - 1);

    localparam t_acc RND_POS = t_acc'(1) <<< (OUT_SHIFT - 1);
    localparam t_acc RND_NEG = RND_POS - t_acc'(1);
    localparam t_acc SAT_HI  = t_acc'(signed'(32'h7FFF_FFFF));
    localparam t_acc SAT_LO  = t_acc'(signed'(32'h8000_0000));

    // Weights with 16 fractional bits, index 0 is the oldest sample.
    localparam t_coef_set COEF_TABLE [TAPS] = '{
        '{smooth: -16'sd5500,  first: -16'sd2979, second:  16'sd2291},
        '{smooth:  16'sd1375,  first: -16'sd2383, second:  16'sd917},
        '{smooth:  16'sd6722,  first: -16'sd1787, second: -16'sd153},
        '{smooth:  16'sd10541, first: -16'sd1192, second: -16'sd917},
        '{smooth:  16'sd12832, first: -16'sd596,  second: -16'sd1375},
        '{smooth:  16'sd13596, first:  16'sd0,    second: -16'sd1528},
        '{smooth:  16'sd12832, first:  16'sd596,  second: -16'sd1375},
        '{smooth:  16'sd10541, first:  16'sd1192, second: -16'sd917},
        '{smooth:  16'sd6722,  first:  16'sd1787, second: -16'sd153},
        '{smooth:  16'sd1375,  first:  16'sd2383, second:  16'sd917},
        '{smooth: -16'sd5500,  first:  16'sd2979, second:  16'sd2291}
    };

    function automatic t_acc tap_mac(t_acc sum, t_sample x, t_coef c);
        logic signed [SAMPLE_W:0]        xs;
        logic signed [SAMPLE_W+COEF_W:0] prod;
        xs   = signed'({1'b0, x});
        prod = xs * c;
        return sum + t_acc'(prod);
    endfunction

    function automatic t_sums tap_mac_set(t_sums sum, t_sample x, t_coef_set c);
        t_sums r;
        r.smooth = tap_mac(sum.smooth, x, c.smooth);
        r.first  = tap_mac(sum.first,  x, c.first);
        r.second = tap_mac(sum.second, x, c.second);
        return r;
    endfunction

endpackage

// File: rtl/sgsd_if.sv
interface sgsd_sample_if;
    logic              valid;
    logic              ready;
    sgsd_pkg::t_sample sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface sgsd_result_if;
    logic           valid;
    logic           ready;
    sgsd_pkg::t_out smoothed;
    sgsd_pkg::t_out first_derivative;
    sgsd_pkg::t_out second_derivative;

    modport source (output valid, output smoothed, output first_derivative,
                    output second_derivative, input ready);
    modport sink   (input valid, input smoothed, input first_derivative,
                    input second_derivative, output ready);
endinterface

// File: rtl/savitzky_golay_smooth_and_derivatives_core.sv
// A result word is registered, valid in the cycle after the word that completes it.
// One word per cycle unless the output stalls, set by the transposed multiply-add chain.
// The first ten words after reset fill the window and give no result.
// Reset clears the fill count and the output valid; cell sums need no reset.
`include "assert_macros.svh"

module savitzky_golay_smooth_and_derivatives_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    sgsd_sample_if.sink          i_in,
    sgsd_result_if.source        o_out
);

    localparam int TAPS = sgsd_pkg::TAPS;

    sgsd_pkg::t_fill   r_fill;
    sgsd_pkg::t_fill   n_fill;
    logic              r_out_valid;
    sgsd_pkg::t_result r_result;
    sgsd_pkg::t_result w_head;
    sgsd_pkg::t_sums   w_cell_sum [1:TAPS];
    logic              w_accept;
    logic              w_produce;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_produce  = w_accept && (r_fill >= sgsd_pkg::FILL_LAST);
    assign n_fill     = (r_fill == sgsd_pkg::FILL_FULL) ? r_fill
                                                        : r_fill + sgsd_pkg::t_fill'(1);

    assign w_cell_sum[TAPS] = '0;

    for (genvar j = 1; j < TAPS; j++) begin : g_cell
        sgsd_cell u_cell (
            .i_clk    (i_clk),
            .i_en     (w_accept),
            .i_sample (i_in.sample),
            .i_coef   (sgsd_pkg::COEF_TABLE[TAPS-1-j]),
            .i_sum    (w_cell_sum[j+1]),
            .o_sum    (w_cell_sum[j])
        );
    end

    sgsd_head u_head (
        .i_sample (i_in.sample),
        .i_coef   (sgsd_pkg::COEF_TABLE[TAPS-1]),
        .i_sum    (w_cell_sum[1]),
        .o_result (w_head)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_fill <= n_fill;
            end
            if (w_produce) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_produce) begin
            r_result <= w_head;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.smoothed          = r_result.smoothed;
    assign o_out.first_derivative  = r_result.first_derivative;
    assign o_out.second_derivative = r_result.second_derivative;

    `SGSD_ASSERT_IMP(a_rise_has_word, i_clk, i_rst_n, $rose(r_out_valid), $past(w_accept))
    `SGSD_ASSERT_NXT(a_no_early_result, i_clk, i_rst_n, w_accept && (r_fill < sgsd_pkg::FILL_LAST), !$rose(r_out_valid))
    `SGSD_ASSERT_NXT(a_full_gives_result, i_clk, i_rst_n, w_produce, r_out_valid)
    `SGSD_ASSERT_IMP(a_fill_bounded, i_clk, i_rst_n, 1'b1, r_fill <= sgsd_pkg::FILL_FULL)

endmodule

// File: rtl/sgsd_cell.sv
module sgsd_cell (
    input  logic                i_clk,
    input  logic                i_en,
    input  sgsd_pkg::t_sample   i_sample,
    input  sgsd_pkg::t_coef_set i_coef,
    input  sgsd_pkg::t_sums     i_sum,
    output sgsd_pkg::t_sums     o_sum
);

    sgsd_pkg::t_sums r_sum;
    sgsd_pkg::t_sums n_sum;

    assign n_sum = sgsd_pkg::tap_mac_set(i_sum, i_sample, i_coef);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

// File: rtl/sgsd_head.sv
module sgsd_head (
    input  sgsd_pkg::t_sample   i_sample,
    input  sgsd_pkg::t_coef_set i_coef,
    input  sgsd_pkg::t_sums     i_sum,
    output sgsd_pkg::t_result   o_result
);

    sgsd_pkg::t_sums w_total;

    function automatic sgsd_pkg::t_out round_sat(sgsd_pkg::t_acc v);
        sgsd_pkg::t_acc t;
        t = (v + (v[sgsd_pkg::ACC_W-1] ? sgsd_pkg::RND_NEG : sgsd_pkg::RND_POS))
            >>> sgsd_pkg::OUT_SHIFT;
        if (t > sgsd_pkg::SAT_HI) begin
            t = sgsd_pkg::SAT_HI;
        end else if (t < sgsd_pkg::SAT_LO) begin
            t = sgsd_pkg::SAT_LO;
        end
        return t[sgsd_pkg::OUT_W-1:0];
    endfunction

    assign w_total = sgsd_pkg::tap_mac_set(i_sum, i_sample, i_coef);

    assign o_result.smoothed          = round_sat(w_total.smooth);
    assign o_result.first_derivative  = round_sat(w_total.first);
    assign o_result.second_derivative = round_sat(w_total.second);

endmodule
